// ===== rtl/core/ctpc_pkg.sv =====
package ctpc_pkg;

   // Request opcodes
   typedef enum logic [2:0] {
      OP_STATUS_RD = 3'd0,
      OP_CTRL_WR   = 3'd1,
      OP_DATA_RD   = 3'd2,
      OP_DATA_WR   = 3'd3,
      OP_RX_CHAR   = 3'd4,
      OP_TX_DONE   = 3'd5
   } op_type;

   // Per-port status bit positions
   localparam int ST_TRDY = 0;   // printer ready
   localparam int ST_TBSY = 1;   // printer busy
   localparam int ST_KRDY = 2;   // keyboard ready
   localparam int ST_KBSY = 3;   // keyboard busy
   localparam int ST_KTST = 4;   // keyboard test

   // Control word bit positions
   localparam int CW_SET_TRDY = 3;
   localparam int CW_SET_TBSY = 4;
   localparam int CW_SET_KRDY = 5;
   localparam int CW_SET_KBSY = 6;
   localparam int CW_CLR_TRDY = 7;
   localparam int CW_CLR_TBSY = 8;
   localparam int CW_CLR_KRDY = 9;
   localparam int CW_CLR_KBSY = 10;
   localparam int CW_SET_KTST = 11;
   localparam int CW_PORT_LO  = 12;
   localparam int CW_PORT_HI  = 14;
   localparam int CW_ALL_IRQ  = 15;
   localparam int CW_PORT_SEL = 17;

   typedef logic [4:0] status_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [35:0] write_data;
      logic [7:0]  rx_char;
      logic        rx_break;
   } item_type;

   typedef struct packed {
      logic [11:0] read_data;
      logic        irq_pending;
      logic [2:0]  irq_level;
      logic        tx_valid;
      logic [6:0]  tx_char;
   } result_type;

   // Status read word: level in the low bits, status bits spread over the word
   function automatic logic [11:0] status_word(input logic [2:0] level,
                                               input status_type s);
      logic [11:0] w;
      w     = {9'd0, level};
      w[3]  = s[ST_TRDY];
      w[4]  = s[ST_TBSY];
      w[5]  = s[ST_KRDY];
      w[6]  = s[ST_KBSY];
      w[11] = s[ST_KTST];
      return w;
   endfunction

endpackage

// ===== rtl/core/ctpc_in_stage.sv =====
module ctpc_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ctpc_pkg::item_type req_item,
   input  logic               advance,
   output logic               fire,
   output ctpc_pkg::item_type item
);
   import ctpc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   // Hold the request while the result side cannot take it
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign fire      = valid_ff & advance;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/core/ctpc_core.sv =====
module ctpc_core #(
   parameter int PORT_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ctpc_pkg::item_type   item,
   output ctpc_pkg::result_type result
);
   import ctpc_pkg::*;

   localparam int PortW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

   logic [PortW-1:0] sel_ff, sel_in;
   logic [2:0]       level_ff, level_in;
   logic             all_irq_ff, all_irq_in;
   logic             flag_ff, flag_in;
   status_type       status_ff [PORT_COUNT];
   logic [6:0]       rx_ff     [PORT_COUNT];
   logic [6:0]       tx_ff     [PORT_COUNT];

   logic [PortW-1:0] idx;
   status_type       s_cur, s_new;
   logic [6:0]       rx_new, tx_new;
   logic [2:0]       np;
   logic             raise;
   logic [11:0]      rd;
   logic             txv;
   logic [6:0]       txc;

   // Next state and result for the item at the head of the pipe
   always_comb begin
      sel_in     = sel_ff;
      level_in   = level_ff;
      all_irq_in = all_irq_ff;
      flag_in    = flag_ff;
      np         = item.write_data[CW_PORT_HI:CW_PORT_LO];
      rd         = 12'd0;
      txv        = 1'b0;
      txc        = 7'd0;

      // port select applies before the status update of the same request
      if (op_type'(item.opcode) == OP_CTRL_WR && item.write_data[CW_PORT_SEL] &&
          ({1'b0, np} < 4'(PORT_COUNT))) begin
         sel_in = np[PortW-1:0];
      end
      idx    = sel_in;
      s_cur  = status_ff[idx];
      s_new  = s_cur;
      rx_new = rx_ff[idx];
      tx_new = tx_ff[idx];
      raise  = all_irq_ff | (idx == '0);

      unique case (op_type'(item.opcode))
         OP_STATUS_RD: begin
            rd = status_word(level_ff, s_cur);
         end
         OP_CTRL_WR: begin
            all_irq_in = item.write_data[CW_ALL_IRQ];
            level_in   = item.write_data[2:0];
            // clears first, then sets
            if (item.write_data[CW_CLR_TRDY]) s_new[ST_TRDY] = 1'b0;
            if (item.write_data[CW_CLR_TBSY]) s_new[ST_TBSY] = 1'b0;
            if (item.write_data[CW_CLR_KRDY]) s_new[ST_KRDY] = 1'b0;
            if (item.write_data[CW_CLR_KBSY]) s_new[ST_KBSY] = 1'b0;
            if (item.write_data[CW_SET_TRDY]) s_new[ST_TRDY] = 1'b1;
            if (item.write_data[CW_SET_TBSY]) s_new[ST_TBSY] = 1'b1;
            if (item.write_data[CW_SET_KRDY]) s_new[ST_KRDY] = 1'b1;
            if (item.write_data[CW_SET_KBSY]) s_new[ST_KBSY] = 1'b1;
            if (item.write_data[CW_SET_KTST]) s_new[ST_KTST] = 1'b1;
            flag_in = s_new[ST_TRDY] | s_new[ST_KRDY];
         end
         OP_DATA_RD: begin
            rd             = {5'd0, rx_ff[idx]};
            s_new[ST_KRDY] = 1'b0;
            if (!s_new[ST_TRDY]) flag_in = 1'b0;
         end
         OP_DATA_WR: begin
            tx_new         = item.write_data[6:0];
            s_new[ST_TRDY] = 1'b0;
            s_new[ST_TBSY] = 1'b1;
            if (!s_new[ST_KRDY]) flag_in = 1'b0;
         end
         OP_RX_CHAR: begin
            // ignored on break or while the previous character is unread
            if (!s_cur[ST_KRDY] && !item.rx_break) begin
               rx_new         = item.rx_char[6:0];
               s_new[ST_KRDY] = 1'b1;
               if (raise) flag_in = 1'b1;
            end
         end
         OP_TX_DONE: begin
            if (tx_ff[idx] != 7'd0) begin
               txv = 1'b1;
               txc = tx_ff[idx];
            end
            s_new[ST_TBSY] = 1'b0;
            s_new[ST_TRDY] = 1'b1;
            if (raise) flag_in = 1'b1;
         end
         default: begin
         end
      endcase

      result.read_data   = rd;
      result.irq_pending = flag_in & (level_in != 3'd0);
      result.irq_level   = level_in;
      result.tx_valid    = txv;
      result.tx_char     = txc;
   end

   // Block state, written once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff     <= '0;
         level_ff   <= 3'd0;
         all_irq_ff <= 1'b0;
         flag_ff    <= 1'b0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            status_ff[i] <= '0;
            rx_ff[i]     <= 7'd0;
            tx_ff[i]     <= 7'd0;
         end
      end else if (fire) begin
         sel_ff         <= sel_in;
         level_ff       <= level_in;
         all_irq_ff     <= all_irq_in;
         flag_ff        <= flag_in;
         status_ff[idx] <= s_new;
         rx_ff[idx]     <= rx_new;
         tx_ff[idx]     <= tx_new;
      end
   end

endmodule

// ===== rtl/core/ctpc_out_stage.sv =====
module ctpc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ctpc_pkg::result_type result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ctpc_pkg::result_type rsp_result
);
   import ctpc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // Free when empty or when the held result leaves this cycle
   assign advance    = ~valid_ff | ~rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;
   assign valid_in   = fire | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result;
      end
   end

endmodule

// ===== rtl/core/console_terminal_port_controller.sv =====
// Channel    Ports                                              Direction
// request    req_valid/req_stall, opcode, write_data, rx_char,  in
//            rx_break
// response   rsp_valid/rsp_stall, read_data, irq_pending,       out
//            irq_level, tx_valid, tx_char
//
// One request per cycle while req_stall is low; each request passes through
// the input register, then the result register, before its response is valid.
// Synchronous active-high reset clears all port state, selection, level
// and interrupt flag; no request is taken during reset.
// req_stall rises only when the input register is full and the held
// response is stalled; one request then waits in the input register.
module console_terminal_port_controller #(
   parameter int PORT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [35:0] req_write_data,
   input  logic [7:0]  req_rx_char,
   input  logic        req_rx_break,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_read_data,
   output logic        rsp_irq_pending,
   output logic [2:0]  rsp_irq_level,
   output logic        rsp_tx_valid,
   output logic [6:0]  rsp_tx_char
);
   import ctpc_pkg::*;

   item_type   req_item, item;
   result_type result, rsp_result;
   logic       advance, fire;

   assign req_item = '{opcode:     req_opcode,
                       write_data: req_write_data,
                       rx_char:    req_rx_char,
                       rx_break:   req_rx_break};

   ctpc_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .fire      (fire),
      .item      (item)
   );

   ctpc_core #(
      .PORT_COUNT (PORT_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   ctpc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_read_data   = rsp_result.read_data;
   assign rsp_irq_pending = rsp_result.irq_pending;
   assign rsp_irq_level   = rsp_result.irq_level;
   assign rsp_tx_valid    = rsp_result.tx_valid;
   assign rsp_tx_char     = rsp_result.tx_char;

   // No response straight out of reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Interrupt request is never shown at level zero
   a_irq_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_irq_pending) |-> (rsp_irq_level != 3'd0))
      else $error("interrupt pending at level zero");

   // A sent character is never the null byte
   a_tx_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tx_valid) |-> (rsp_tx_char != 7'd0))
      else $error("null character sent");

   // The input side stalls only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with free result register");

endmodule

// ===== tb/ctpc_checker.sv =====
module ctpc_checker #(
   parameter int PORT_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [35:0] req_write_data,
   input  logic [7:0]  req_rx_char,
   input  logic        req_rx_break,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [11:0] rsp_read_data,
   input  logic        rsp_irq_pending,
   input  logic [2:0]  rsp_irq_level,
   input  logic        rsp_tx_valid,
   input  logic [6:0]  rsp_tx_char,
   output int          mismatches,
   output int          pending,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import ctpc_pkg::*;

   // Shadow copy of the controller state
   status_type port_st [8];
   logic [6:0] rx_hold [8];
   logic [6:0] tx_hold [8];
   logic [2:0] cur_port;
   logic [2:0] cur_level;
   logic       all_ports_irq;
   logic       irq_raised;

   result_type due_responses [$];
   result_type want;
   item_type   seen;

   initial begin
      mismatches = 0;
      checked    = 0;
      pending    = 0;
   end

   // Applies one request to the shadow state and returns the response it owes
   function result_type console_step(input item_type it);
      result_type r;
      status_type s;
      logic [2:0] p;
      r = '0;
      p = cur_port;
      s = port_st[p];
      case (it.opcode)
         OP_STATUS_RD: begin
            r.read_data = {s[ST_KTST], 4'b0000, s[ST_KBSY], s[ST_KRDY],
                           s[ST_TBSY], s[ST_TRDY], cur_level};
         end
         OP_CTRL_WR: begin
            if (it.write_data[CW_PORT_SEL] &&
                it.write_data[CW_PORT_HI:CW_PORT_LO] < PORT_COUNT) begin
               cur_port = it.write_data[CW_PORT_HI:CW_PORT_LO];
            end
            p             = cur_port;
            all_ports_irq = it.write_data[CW_ALL_IRQ];
            cur_level     = it.write_data[2:0];
            s             = port_st[p];
            // clears first, then sets
            if (it.write_data[CW_CLR_TRDY]) s[ST_TRDY] = 1'b0;
            if (it.write_data[CW_CLR_TBSY]) s[ST_TBSY] = 1'b0;
            if (it.write_data[CW_CLR_KRDY]) s[ST_KRDY] = 1'b0;
            if (it.write_data[CW_CLR_KBSY]) s[ST_KBSY] = 1'b0;
            if (it.write_data[CW_SET_TRDY]) s[ST_TRDY] = 1'b1;
            if (it.write_data[CW_SET_TBSY]) s[ST_TBSY] = 1'b1;
            if (it.write_data[CW_SET_KRDY]) s[ST_KRDY] = 1'b1;
            if (it.write_data[CW_SET_KBSY]) s[ST_KBSY] = 1'b1;
            if (it.write_data[CW_SET_KTST]) s[ST_KTST] = 1'b1;
            port_st[p] = s;
            irq_raised = s[ST_TRDY] | s[ST_KRDY];
         end
         OP_DATA_RD: begin
            r.read_data = {5'd0, rx_hold[p]};
            port_st[p][ST_KRDY] = 1'b0;
            if (!port_st[p][ST_TRDY]) irq_raised = 1'b0;
         end
         OP_DATA_WR: begin
            tx_hold[p] = it.write_data[6:0];
            port_st[p][ST_TRDY] = 1'b0;
            port_st[p][ST_TBSY] = 1'b1;
            if (!port_st[p][ST_KRDY]) irq_raised = 1'b0;
         end
         OP_RX_CHAR: begin
            // dropped while a character waits or on a break
            if (!s[ST_KRDY] && !it.rx_break) begin
               rx_hold[p] = it.rx_char[6:0];
               port_st[p][ST_KRDY] = 1'b1;
               if (all_ports_irq || cur_port == 3'd0) irq_raised = 1'b1;
            end
         end
         OP_TX_DONE: begin
            // a zero byte is not sent, but the printer still goes ready
            if (tx_hold[p] != 7'd0) begin
               r.tx_valid = 1'b1;
               r.tx_char  = tx_hold[p];
            end
            port_st[p][ST_TBSY] = 1'b0;
            port_st[p][ST_TRDY] = 1'b1;
            if (all_ports_irq || cur_port == 3'd0) irq_raised = 1'b1;
         end
         default: begin
         end
      endcase
      r.irq_pending = irq_raised && (cur_level != 3'd0);
      r.irq_level   = cur_level;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [35:0] got,
                                  input logic [35:0] exp_val);
      mismatches++;
      $display("%0t ns  response %0d: %s got 'h%0h, expected 'h%0h",
               $time, checked, what, got, exp_val);
   endtask

   // Compare responses in order, then queue the prediction for a new request
   always @(posedge clock) begin
      if (reset) begin
         foreach (port_st[i]) begin
            port_st[i] = '0;
            rx_hold[i] = '0;
            tx_hold[i] = '0;
         end
         cur_port      = '0;
         cur_level     = '0;
         all_ports_irq = 1'b0;
         irq_raised    = 1'b0;
         due_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report_mismatch("response with nothing due", '0, '0);
            end else begin
               want = due_responses.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", 36'(rsp_read_data),
                                  36'(want.read_data));
               if (rsp_irq_pending !== want.irq_pending)
                  report_mismatch("irq_pending", 36'(rsp_irq_pending),
                                  36'(want.irq_pending));
               if (rsp_irq_level !== want.irq_level)
                  report_mismatch("irq_level", 36'(rsp_irq_level),
                                  36'(want.irq_level));
               if (rsp_tx_valid !== want.tx_valid)
                  report_mismatch("tx_valid", 36'(rsp_tx_valid),
                                  36'(want.tx_valid));
               if (rsp_tx_char !== want.tx_char)
                  report_mismatch("tx_char", 36'(rsp_tx_char),
                                  36'(want.tx_char));
               checked++;
            end
         end
         if (req_valid && !req_stall) begin
            seen = {req_opcode, req_write_data, req_rx_char, req_rx_break};
            due_responses.push_back(console_step(seen));
         end
      end
      pending <= due_responses.size();
   end

endmodule

// ===== tb/console_terminal_port_controller_tb.sv =====
module console_terminal_port_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctpc_pkg::*;

   localparam int PORT_COUNT     = 8;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   // opcodes the block does not decode
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_opcode;
   logic [35:0] req_write_data;
   logic [7:0]  req_rx_char;
   logic        req_rx_break;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_read_data;
   logic        rsp_irq_pending;
   logic [2:0]  rsp_irq_level;
   logic        rsp_tx_valid;
   logic [6:0]  rsp_tx_char;

   int mismatches;
   int pending;
   int checked;
   int quiet_cycles = 0;
   int op_count [8] = '{default: 0};

   bit req_calm     = 1'b0;
   bit rsp_calm     = 1'b0;
   bit hold_off_req = 1'b0;

   always #5 clock = ~clock;

   console_terminal_port_controller #(
      .PORT_COUNT(PORT_COUNT)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_write_data  (req_write_data),
      .req_rx_char     (req_rx_char),
      .req_rx_break    (req_rx_break),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_irq_level   (rsp_irq_level),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_char     (rsp_tx_char)
   );

   ctpc_checker #(
      .PORT_COUNT(PORT_COUNT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_write_data  (req_write_data),
      .req_rx_char     (req_rx_char),
      .req_rx_break    (req_rx_break),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pending (rsp_irq_pending),
      .rsp_irq_level   (rsp_irq_level),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_char     (rsp_tx_char),
      .mismatches      (mismatches),
      .pending         (pending),
      .checked         (checked)
   );

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request and hold it until taken
   task automatic send_request(input logic [2:0] op, input logic [35:0] wd,
                               input logic [7:0] ch, input logic brk);
      int gap;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_write_data <= wd;
      req_rx_char    <= ch;
      req_rx_break   <= brk;
      op_count[op]++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic random_request();
      int          roll;
      logic [2:0]  op;
      logic [35:0] wd;
      roll = $urandom_range(0, 99);
      if (roll < 14)      op = OP_STATUS_RD;
      else if (roll < 34) op = OP_CTRL_WR;
      else if (roll < 50) op = OP_DATA_RD;
      else if (roll < 64) op = OP_DATA_WR;
      else if (roll < 80) op = OP_RX_CHAR;
      else if (roll < 96) op = OP_TX_DONE;
      else                op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      wd = 36'({$urandom(), $urandom()});
      // half the control writes only clear, so ready bits do drop
      if (op == OP_CTRL_WR && $urandom_range(0, 1)) begin
         wd[CW_SET_KBSY:CW_SET_TRDY] = '0;
         wd[CW_SET_KTST]             = 1'b0;
      end
      send_request(op, wd, 8'($urandom()), $urandom_range(0, 7) == 0);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Response side back-pressure
   initial begin
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (rsp_calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("** console_terminal_port_controller: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [35:0] cw;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= OP_STATUS_RD;
      req_write_data <= '0;
      req_rx_char    <= '0;
      req_rx_break   <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: each operation, the extremes and the corner cases
      send_request(OP_STATUS_RD, '0, '0, 1'b0);
      cw = '0;
      cw[2:0] = 3'd7;
      cw[CW_SET_KBSY:CW_SET_TRDY] = '1;
      cw[CW_SET_KTST] = 1'b1;
      cw[CW_ALL_IRQ]  = 1'b1;
      cw[CW_PORT_SEL] = 1'b1;
      send_request(OP_CTRL_WR, cw, '0, 1'b0);
      send_request(OP_STATUS_RD, '0, '0, 1'b0);
      send_request(OP_DATA_RD, '0, '0, 1'b0);
      send_request(OP_DATA_WR, 36'h7f, '0, 1'b0);
      send_request(OP_TX_DONE, '0, '0, 1'b0);
      send_request(OP_DATA_WR, '1, '1, 1'b1);
      // byte to send is zero: nothing goes out, printer still ready
      send_request(OP_DATA_WR, 36'h80, '0, 1'b0);
      send_request(OP_TX_DONE, '0, '0, 1'b0);
      // transmit done with the printer not busy
      send_request(OP_TX_DONE, '0, '0, 1'b0);
      send_request(OP_RX_CHAR, '0, 8'hff, 1'b0);
      // character arriving while one waits is dropped
      send_request(OP_RX_CHAR, '0, 8'h41, 1'b0);
      send_request(OP_DATA_RD, '0, '0, 1'b0);
      // break is dropped
      send_request(OP_RX_CHAR, '0, 8'h55, 1'b1);
      send_request(OP_RX_CHAR, '0, 8'h00, 1'b0);
      cw = '0;
      cw[CW_CLR_KBSY:CW_CLR_TRDY] = '1;
      send_request(OP_CTRL_WR, cw, '0, 1'b0);
      send_request(OP_STATUS_RD, '0, '0, 1'b0);
      // port 5 with the all-ports enable off: events must not raise the flag
      cw = '0;
      cw[2:0] = 3'd3;
      cw[CW_PORT_HI:CW_PORT_LO] = 3'd5;
      cw[CW_PORT_SEL] = 1'b1;
      send_request(OP_CTRL_WR, cw, '0, 1'b0);
      send_request(OP_RX_CHAR, '0, 8'h2a, 1'b0);
      send_request(OP_TX_DONE, '0, '0, 1'b0);
      // port field without the select bit, level zero with the flag set
      cw = '0;
      cw[CW_PORT_HI:CW_PORT_LO] = 3'd7;
      cw[CW_SET_TRDY] = 1'b1;
      send_request(OP_CTRL_WR, cw, '0, 1'b0);
      send_request(OP_STATUS_RD, '0, '0, 1'b0);
      send_request(OP_SPARE_6, '1, 8'hff, 1'b1);
      send_request(OP_SPARE_7, '0, '0, 1'b0);
      send_request(OP_CTRL_WR, '1, '0, 1'b0);
      send_request(OP_STATUS_RD, '0, '0, 1'b0);
      drain();

      // Random, idling on both sides
      repeat (500) random_request();

      // Random, back to back on both sides
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      repeat (300) random_request();
      rsp_calm = 1'b0;

      // Long response hold-off while requests keep coming
      hold_off_req = 1'b1;
      repeat (200) random_request();
      req_calm = 1'b0;
      drain();

      repeat (700) random_request();

      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d requests: %0d status reads, %0d control writes, %0d data reads,",
               op_count.sum(), op_count[OP_STATUS_RD], op_count[OP_CTRL_WR],
               op_count[OP_DATA_RD]);
      $display("%0d data writes, %0d characters, %0d transmit-done, %0d spare; %0d checked",
               op_count[OP_DATA_WR], op_count[OP_RX_CHAR], op_count[OP_TX_DONE],
               op_count[OP_SPARE_6] + op_count[OP_SPARE_7], checked);
      if (mismatches == 0 && pending == 0) begin
         $display("** console_terminal_port_controller: PASSED **");
      end else begin
         $display("** console_terminal_port_controller: FAILED **");
      end
      $finish;
   end

endmodule
